// ----- rtl/fedl_pkg.sv -----
package fedl_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned TYPE_LSB = 13;

  localparam logic [1:0] MODE_ASSERT   = 2'd0;
  localparam logic [1:0] MODE_DEASSERT = 2'd1;
  localparam logic [1:0] MODE_CLR_TYPE = 2'd2;
  localparam logic [1:0] MODE_CLR_ALL  = 2'd3;

  localparam logic [2:0] STS_LOGGED    = 3'd0;
  localparam logic [2:0] STS_DUPLICATE = 3'd1;
  localparam logic [2:0] STS_FREED     = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_FULL      = 3'd4;
  localparam logic [2:0] STS_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] fault_code;
    logic [TYPE_W-1:0] target_type;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  log_slot;
    logic [11:0] sequence_index;
    logic [7:0]  log_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_COMMIT
  } fedl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic sweep;
    logic commit;
  } fedl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic sweep_done;
    logic out_free;
  } fedl_sts_t;

  function automatic logic [TYPE_W-1:0] type_of_code(input logic [CODE_W-1:0] code);
    type_of_code = code[TYPE_LSB +: TYPE_W];
  endfunction

endpackage

// ----- rtl/fedl_ram.sv -----
module fedl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fedl_ctrl.sv -----
module fedl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_mode_i,
  output logic               in_stall_o,
  input  fedl_pkg::fedl_sts_t sts_i,
  output fedl_pkg::fedl_cmd_t cmd_o
);
  import fedl_pkg::*;

  fedl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_mode_i == MODE_CLR_ALL) ? ST_SWEEP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

// ----- rtl/fedl_dpath.sv -----
module fedl_dpath #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned LOG_SLOTS     = 128,
  parameter int unsigned SEQ_LIMIT     = 4095
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fedl_pkg::in_item_t   in_item_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  input  fedl_pkg::fedl_cmd_t  cmd_i,
  output fedl_pkg::fedl_sts_t  sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fedl_pkg::out_item_t  out_item_o
);
  import fedl_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SLOT_W = $clog2(LOG_SLOTS + 1);
  localparam int unsigned SEQ_W  = $clog2(SEQ_LIMIT + 1);
  localparam logic [CNT_W-1:0]  END_CNT  = CNT_W'(TABLE_ENTRIES);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(LOG_SLOTS);
  localparam logic [SEQ_W-1:0]  SEQ_MAX  = SEQ_W'(SEQ_LIMIT);

  in_item_t          item_q;
  logic [TYPE_W-1:0] temp_type_q;

  logic [CNT_W-1:0]  addr_q, addr_d;
  logic              at_end;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              match_hit_q, match_hit_d;
  logic [IDX_W-1:0]  match_idx_q, match_idx_d;
  logic              free_hit_q, free_hit_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, res;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CODE_W-1:0] ram_wdata, ram_rdata;

  logic              is_temp, dup, do_log;

  fedl_ram #(
    .WIDTH(CODE_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(addr_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign at_end  = (addr_q == END_CNT);
  assign ram_re  = cmd_i.scan && !at_end;
  assign is_temp = (type_of_code(item_q.fault_code) == temp_type_q);
  assign dup     = !is_temp && match_hit_q;
  assign do_log  = cmd_i.commit && (item_q.mode == MODE_ASSERT) && !dup && free_hit_q;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = '0;
    end else if ((cmd_i.scan || cmd_i.sweep) && !at_end) begin
      addr_d = addr_q + 1'b1;
    end
  end

  always_comb begin
    match_hit_d = match_hit_q;
    match_idx_d = match_idx_q;
    free_hit_d  = free_hit_q;
    free_idx_d  = free_idx_q;
    if (cmd_i.load) begin
      match_hit_d = 1'b0;
      free_hit_d  = 1'b0;
    end else if (rd_vld_q) begin
      if (!match_hit_q && ram_rdata == item_q.fault_code) begin
        match_hit_d = 1'b1;
        match_idx_d = rd_idx_q;
      end
      if (!free_hit_q && ram_rdata == '0) begin
        free_hit_d = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q[IDX_W-1:0];
    ram_wdata = '0;
    if (cmd_i.sweep && !at_end) begin
      ram_we = 1'b1;
    end else if (rd_vld_q && item_q.mode == MODE_CLR_TYPE &&
                 type_of_code(ram_rdata) == item_q.target_type) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_q;
    end else if (do_log) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx_q;
      ram_wdata = item_q.fault_code;
    end else if (cmd_i.commit && item_q.mode == MODE_DEASSERT && !is_temp && match_hit_q) begin
      ram_we    = 1'b1;
      ram_waddr = match_idx_q;
    end
  end

  always_comb begin
    slot_d = slot_q;
    seq_d  = seq_q;
    cnt_d  = cnt_q;
    res    = '0;
    if (cmd_i.commit) begin
      case (item_q.mode)
        MODE_ASSERT: begin
          if (dup) begin
            res.status = STS_DUPLICATE;
          end else if (free_hit_q) begin
            res.status         = STS_LOGGED;
            res.log_slot       = 8'(slot_q);
            res.sequence_index = 12'(seq_q);
            slot_d = (slot_q >= SLOT_MAX) ? SLOT_W'(1) : slot_q + 1'b1;
            seq_d  = (seq_q >= SEQ_MAX) ? SEQ_W'(1) : seq_q + 1'b1;
            if (cnt_q < SLOT_MAX) begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            res.status = STS_FULL;
          end
        end
        MODE_DEASSERT: begin
          res.status = (!is_temp && match_hit_q) ? STS_FREED : STS_NOT_FOUND;
        end
        MODE_CLR_TYPE: begin
          res.status = STS_CLEARED;
        end
        MODE_CLR_ALL: begin
          res.status = STS_CLEARED;
          seq_d      = '0;
          cnt_d      = '0;
        end
        default: begin
          res.status = STS_CLEARED;
        end
      endcase
      res.log_count = 8'(cnt_d);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_type_q <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      slot_q      <= SLOT_W'(1);
      seq_q       <= SEQ_W'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        temp_type_q <= cfg_wdata_i;
      end
      addr_q      <= addr_d;
      rd_vld_q    <= ram_re;
      match_hit_q <= match_hit_d;
      free_hit_q  <= free_hit_d;
      slot_q      <= slot_d;
      seq_q       <= seq_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
    rd_idx_q    <= addr_q[IDX_W-1:0];
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
  end

  assign sts_o.scan_done  = at_end && !rd_vld_q;
  assign sts_o.sweep_done = at_end;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/fault_event_dedup_logger.sv -----
// Fault event logger with duplicate suppression. Each input transfer is one
// event (assert, deassert, clear one type, clear all) and yields exactly one
// output transfer. The active-code table sits in a single RAM that is walked
// one entry per cycle, through its registered read port for every event but
// clear-all, which only writes. After reset a clearing pass zeroes the table
// while in_stall_o is held high. The result register holds a finished
// result while the next event is taken in.
module fault_event_dedup_logger #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned LOG_SLOTS     = 128,
  parameter int unsigned SEQ_LIMIT     = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fedl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fedl_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i
);
  import fedl_pkg::*;

  fedl_cmd_t cmd;
  fedl_sts_t sts;

  fedl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_mode_i (in_item_i.mode),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fedl_dpath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LOG_SLOTS    (LOG_SLOTS),
    .SEQ_LIMIT    (SEQ_LIMIT)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced without an event in progress");

  a_no_slot_unless_logged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STS_LOGGED |->
      out_item_o.log_slot == '0 && out_item_o.sequence_index == '0)
    else $error("slot or sequence given to an event that was not logged");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import fedl_pkg::*;

  localparam int unsigned TABLE_ENTRIES   = 256;
  localparam int unsigned LOG_SLOTS       = 128;
  localparam int unsigned SEQ_LIMIT       = 4095;
  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 800;
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned DIRECTED_ROWS   = 25;
  localparam out_item_t   FROM_MODEL      = '0;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] cfg_value;
    in_item_t   ev;
    logic       pinned;
    out_item_t  want;
  } directed_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_item_o;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  // predictor state
  logic [CODE_W-1:0] held_codes [TABLE_ENTRIES];
  logic [7:0]        slot_next;
  logic [11:0]       seq_next;
  logic [7:0]        records;
  logic [TYPE_W-1:0] temp_type;

  out_item_t         awaited_reports [$];
  logic [CODE_W-1:0] recent_codes [$];
  int unsigned       mismatch_count;
  int unsigned       quiet_cycles;
  int unsigned       sender_idle_pct;
  int unsigned       receiver_idle_pct;
  bit                hold_off_req;

  // temperature type is 0 up to the config row, 7 after it
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    {1'b0, 3'd0, MODE_ASSERT,   16'hFFFF, 3'd0, 1'b1, STS_LOGGED,    8'd1, 12'd1, 8'd1},
    {1'b0, 3'd0, MODE_ASSERT,   16'hFFFF, 3'd0, 1'b1, STS_DUPLICATE, 8'd0, 12'd0, 8'd1},
    {1'b0, 3'd0, MODE_ASSERT,   16'h2000, 3'd7, 1'b1, STS_LOGGED,    8'd2, 12'd2, 8'd2},
    {1'b0, 3'd0, MODE_DEASSERT, 16'hFFFF, 3'd0, 1'b1, STS_FREED,     8'd0, 12'd0, 8'd2},
    {1'b0, 3'd0, MODE_DEASSERT, 16'hFFFF, 3'd0, 1'b1, STS_NOT_FOUND, 8'd0, 12'd0, 8'd2},
    {1'b0, 3'd0, MODE_ASSERT,   16'h0005, 3'd0, 1'b1, STS_LOGGED,    8'd3, 12'd3, 8'd3},
    {1'b0, 3'd0, MODE_ASSERT,   16'h0005, 3'd0, 1'b1, STS_LOGGED,    8'd4, 12'd4, 8'd4},
    {1'b0, 3'd0, MODE_DEASSERT, 16'h0005, 3'd0, 1'b1, STS_NOT_FOUND, 8'd0, 12'd0, 8'd4},
    {1'b0, 3'd0, MODE_ASSERT,   16'h0000, 3'd0, 1'b1, STS_LOGGED,    8'd5, 12'd5, 8'd5},
    {1'b0, 3'd0, MODE_DEASSERT, 16'h0000, 3'd0, 1'b1, STS_NOT_FOUND, 8'd0, 12'd0, 8'd5},
    {1'b0, 3'd0, MODE_CLR_TYPE, 16'h0000, 3'd1, 1'b1, STS_CLEARED,   8'd0, 12'd0, 8'd5},
    {1'b0, 3'd0, MODE_DEASSERT, 16'h2000, 3'd0, 1'b1, STS_NOT_FOUND, 8'd0, 12'd0, 8'd5},
    {1'b0, 3'd0, MODE_CLR_TYPE, 16'hFFFF, 3'd0, 1'b1, STS_CLEARED,   8'd0, 12'd0, 8'd5},
    {1'b0, 3'd0, MODE_ASSERT,   16'h1FFF, 3'd0, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_CLR_ALL,  16'h0000, 3'd0, 1'b1, STS_CLEARED,   8'd0, 12'd0, 8'd0},
    {1'b0, 3'd0, MODE_ASSERT,   16'hE001, 3'd0, 1'b1, STS_LOGGED,    8'd7, 12'd0, 8'd1},
    {1'b1, 3'd7, MODE_ASSERT,   16'h0000, 3'd0, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_ASSERT,   16'hE001, 3'd0, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_DEASSERT, 16'hE001, 3'd0, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_ASSERT,   16'h0000, 3'd0, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_DEASSERT, 16'h0000, 3'd0, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_ASSERT,   16'h5555, 3'd5, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_ASSERT,   16'hAAAA, 3'd2, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_CLR_TYPE, 16'h0000, 3'd7, 1'b0, FROM_MODEL},
    {1'b0, 3'd0, MODE_CLR_ALL,  16'hFFFF, 3'd7, 1'b0, FROM_MODEL}
  };

  fault_event_dedup_logger #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LOG_SLOTS    (LOG_SLOTS),
    .SEQ_LIMIT    (SEQ_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic out_item_t log_event(input in_item_t ev);
    out_item_t report;
    bit        is_temp;
    bit        hit;
    report  = '0;
    is_temp = (ev.fault_code[TYPE_LSB +: TYPE_W] == temp_type);
    hit     = 1'b0;
    case (ev.mode)
      MODE_ASSERT: begin
        if (!is_temp) begin
          foreach (held_codes[i]) if (held_codes[i] == ev.fault_code) hit = 1'b1;
        end
        if (hit) begin
          report.status = STS_DUPLICATE;
        end else begin
          report.status = STS_FULL;
          // first free entry; a zero code leaves it looking free
          foreach (held_codes[i]) begin
            if (report.status == STS_FULL && held_codes[i] == '0) begin
              held_codes[i] = ev.fault_code;
              report.status = STS_LOGGED;
            end
          end
          if (report.status == STS_LOGGED) begin
            report.log_slot       = slot_next;
            report.sequence_index = seq_next;
            seq_next  = (seq_next == SEQ_LIMIT) ? 12'd1 : seq_next + 12'd1;
            slot_next = (slot_next == LOG_SLOTS) ? 8'd1 : slot_next + 8'd1;
            if (records < LOG_SLOTS) records = records + 8'd1;
          end
        end
      end
      MODE_DEASSERT: begin
        report.status = STS_NOT_FOUND;
        if (!is_temp) begin
          foreach (held_codes[i]) begin
            if (!hit && held_codes[i] == ev.fault_code) begin
              held_codes[i] = '0;
              hit = 1'b1;
              report.status = STS_FREED;
            end
          end
        end
      end
      MODE_CLR_TYPE: begin
        foreach (held_codes[i]) begin
          if (held_codes[i][TYPE_LSB +: TYPE_W] == ev.target_type) held_codes[i] = '0;
        end
        report.status = STS_CLEARED;
      end
      default: begin
        foreach (held_codes[i]) held_codes[i] = '0;
        seq_next      = '0;
        records       = '0;
        report.status = STS_CLEARED;
      end
    endcase
    report.log_count = records;
    return report;
  endfunction

  function automatic in_item_t random_event();
    in_item_t    ev;
    int unsigned roll;
    roll           = $urandom_range(0, 99);
    ev.mode        = (roll < 50) ? MODE_ASSERT : (roll < 80) ? MODE_DEASSERT :
                     (roll < 93) ? MODE_CLR_TYPE : MODE_CLR_ALL;
    ev.fault_code  = 16'($urandom_range(0, 16'hFFFF));
    ev.target_type = 3'($urandom_range(0, 7));
    roll           = $urandom_range(0, 99);
    if (roll < 45 && recent_codes.size() != 0) begin
      ev.fault_code = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
      if (ev.mode == MODE_CLR_TYPE) ev.target_type = ev.fault_code[TYPE_LSB +: TYPE_W];
    end else if (roll < 65) begin
      ev.fault_code[TYPE_LSB +: TYPE_W] = temp_type;
    end else if (roll < 70) begin
      ev.fault_code = '0;
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
  endtask

  task automatic send_event(input in_item_t ev, input logic pinned, input out_item_t want);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = log_event(ev);
    awaited_reports.push_back(pinned ? want : predicted);
    if (ev.mode == MODE_ASSERT) begin
      recent_codes.push_back(ev.fault_code);
      if (recent_codes.size() > 16) void'(recent_codes.pop_front());
    end
    if ($urandom_range(1, 100) <= sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_reports();
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_temp_type(input logic [2:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    temp_type = value;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_event(random_event(), 1'b0, FROM_MODEL);
  endtask

  always @(posedge clk_i) begin : report_check
    out_item_t awaited;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer: status %0d slot %0d seq %0d count %0d",
                                  out_item_o.status, out_item_o.log_slot,
                                  out_item_o.sequence_index, out_item_o.log_count));
      end else begin
        awaited = awaited_reports.pop_front();
        if (out_item_o.status !== awaited.status || out_item_o.log_slot !== awaited.log_slot ||
            out_item_o.sequence_index !== awaited.sequence_index ||
            out_item_o.log_count !== awaited.log_count) begin
          report_mismatch($sformatf(
            "expected status %0d slot %0d seq %0d count %0d, got %0d %0d %0d %0d",
            awaited.status, awaited.log_slot, awaited.sequence_index, awaited.log_count,
            out_item_o.status, out_item_o.log_slot, out_item_o.sequence_index,
            out_item_o.log_count));
        end
      end
    end
  end

  initial begin : receiver
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_off_req = 1'b0;
      end else if ($urandom_range(1, 100) <= receiver_idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_CYCLES) @(posedge clk_i);
    $display("fault_event_dedup_logger: mismatch");
    $finish;
  end

  initial begin : stimulus
    in_item_t ev;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_req      = 1'b0;
    foreach (held_codes[i]) held_codes[i] = '0;
    slot_next = 8'd1;
    seq_next  = 12'd1;
    records   = '0;
    temp_type = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        wait_all_reports();
        write_temp_type(directed_rows[r].cfg_value);
      end else begin
        send_event(directed_rows[r].ev, directed_rows[r].pinned, directed_rows[r].want);
      end
    end

    wait_all_reports();
    write_temp_type(3'd3);
    sender_idle_pct   = 30;
    receiver_idle_pct = 3;
    run_random(70);

    // receiver holds off while events keep coming
    wait_all_reports();
    write_temp_type(3'd0);
    sender_idle_pct = 0;
    hold_off_req    = 1'b1;
    run_random(10);

    // fill the table with temperature copies, then probe it while full
    wait_all_reports();
    write_temp_type(3'd5);
    sender_idle_pct = 30;
    ev = '0;
    ev.mode = MODE_CLR_ALL;
    send_event(ev, 1'b0, FROM_MODEL);
    repeat (TABLE_ENTRIES) begin
      ev.mode                           = MODE_ASSERT;
      ev.fault_code[12:0]               = 13'($urandom_range(0, 8191));
      ev.fault_code[TYPE_LSB +: TYPE_W] = temp_type;
      ev.target_type                    = 3'($urandom_range(0, 7));
      send_event(ev, 1'b0, FROM_MODEL);
    end
    ev = '0;
    send_event(ev, 1'b0, FROM_MODEL);
    ev.fault_code = 16'hFFFF;
    send_event(ev, 1'b0, FROM_MODEL);
    ev.fault_code = {temp_type, 13'h1ABC};
    send_event(ev, 1'b0, FROM_MODEL);
    ev.mode       = MODE_DEASSERT;
    ev.fault_code = '0;
    send_event(ev, 1'b0, FROM_MODEL);
    run_random(30);

    // no idling from here to the end
    wait_all_reports();
    write_temp_type(3'd7);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(60);

    wait_all_reports();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fault_event_dedup_logger: match");
    end else begin
      $display("fault_event_dedup_logger: mismatch");
    end
    $finish;
  end

endmodule
